[rtl/msort_pkg.sv]
// msort_pkg: shared types for the stable merge sorter
// holds the state machine enums and the sort status struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

    // data word of one element
    localparam int DATA_W = 32;

    // top level sequencer: load a set, sort it, emit it
    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT
    } t_top_state;

    // merge engine: prime both run heads, then merge one element a cycle
    typedef enum logic [1:0] {
        M_IDLE,
        M_PRIME_L,
        M_PRIME_R,
        M_MERGE
    } t_mrg_state;

    // status from the merge engine to the top level
    typedef struct packed {
        logic done;   // one-cycle pulse when all passes are finished
        logic src_b;  // sorted data lies in the buffer ram when set
    } t_sort_stat;

endpackage

`default_nettype wire

[rtl/msort_ram.sv]
// msort_ram: simple dual-port ram, one write and one read port
// read data is registered and holds while no read is issued
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/msort_merger.sv]
// msort_merger: bottom-up merge pass engine over two ping-pong rams
// reads run heads from the source ram, writes merged data to the other
// depends on msort_pkg
`timescale 1ns / 1ps
`default_nettype none

module msort_merger #(
    parameter int MAX_ELEMENTS = 32,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int CW = $clog2(MAX_ELEMENTS + 1),
    localparam int IW = AW + 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [CW-1:0]             i_n,
    input  wire logic [msort_pkg::DATA_W-1:0] i_q,
    output logic                           o_re,
    output logic [AW-1:0]                  o_raddr,
    output logic                           o_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [msort_pkg::DATA_W-1:0]   o_wdata,
    output msort_pkg::t_sort_stat          o_stat
);

    import msort_pkg::*;

    t_mrg_state r_state, n_state;

    logic [IW-1:0] r_width, n_width;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_mid, n_mid;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_l, n_l;
    logic [IW-1:0] r_r, n_r;
    logic [IW-1:0] r_k, n_k;
    logic [DATA_W-1:0] r_lval, n_lval;
    logic [DATA_W-1:0] r_rval, n_rval;
    logic r_q_is_l, n_q_is_l;
    logic r_q_is_r, n_q_is_r;
    logic r_src_b, n_src_b;
    logic r_done, n_done;

    logic [IW-1:0] n_ext;
    logic [IW-1:0] mid_sum;
    logic [IW-1:0] hi_sum;
    logic [IW-1:0] width_dbl;
    logic [IW-1:0] l_inc;
    logic [IW-1:0] r_inc;
    logic [IW-1:0] k_inc;
    logic [DATA_W-1:0] lv;
    logic [DATA_W-1:0] rv;
    logic l_ok;
    logic r_ok;
    logic take_l;

    // run heads: fresh ram data for the side consumed last cycle
    assign lv     = r_q_is_l ? i_q : r_lval;
    assign rv     = r_q_is_r ? i_q : r_rval;
    assign l_ok   = (r_l < r_mid);
    assign r_ok   = (r_r < r_hi);
    // tie takes the left element to keep the sort stable
    assign take_l = !r_ok || (l_ok && ($signed(lv) <= $signed(rv)));

    assign n_ext     = IW'(i_n);
    assign width_dbl = r_width << 1;
    assign mid_sum   = r_lo + r_width;
    assign hi_sum    = r_lo + width_dbl;
    assign l_inc     = r_l + 1'b1;
    assign r_inc     = r_r + 1'b1;
    assign k_inc     = r_k + 1'b1;

    assign o_stat.done  = r_done;
    assign o_stat.src_b = r_src_b;

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= M_IDLE;
            r_done   <= 1'b0;
            r_src_b  <= 1'b0;
            r_q_is_l <= 1'b0;
            r_q_is_r <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_src_b  <= n_src_b;
            r_q_is_l <= n_q_is_l;
            r_q_is_r <= n_q_is_r;
        end
    end

    // run bookkeeping and held head values
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_l     <= n_l;
        r_r     <= n_r;
        r_k     <= n_k;
        r_lval  <= n_lval;
        r_rval  <= n_rval;
    end

    // next state and ram port control
    always_comb begin
        n_state  = r_state;
        n_width  = r_width;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_l      = r_l;
        n_r      = r_r;
        n_k      = r_k;
        n_lval   = r_lval;
        n_rval   = r_rval;
        n_q_is_l = r_q_is_l;
        n_q_is_r = r_q_is_r;
        n_src_b  = r_src_b;
        n_done   = 1'b0;
        o_re     = 1'b0;
        o_raddr  = r_lo[AW-1:0];
        o_we     = 1'b0;
        o_waddr  = r_k[AW-1:0];
        o_wdata  = take_l ? lv : rv;

        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_src_b = 1'b0;
                    n_lo    = '0;
                    n_width = IW'(1);
                    if (n_ext > IW'(1)) begin
                        n_state = M_PRIME_L;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end

            // fetch left head, fix run bounds clipped to the set size
            M_PRIME_L: begin
                o_re    = 1'b1;
                o_raddr = r_lo[AW-1:0];
                n_mid   = (mid_sum < n_ext) ? mid_sum : n_ext;
                n_hi    = (hi_sum < n_ext) ? hi_sum : n_ext;
                n_l     = r_lo;
                n_k     = r_lo;
                n_state = M_PRIME_R;
            end

            // fetch right head, capture left head
            M_PRIME_R: begin
                o_re     = 1'b1;
                o_raddr  = r_mid[AW-1:0];
                n_lval   = i_q;
                n_r      = r_mid;
                n_q_is_l = 1'b0;
                n_q_is_r = 1'b1;
                n_state  = M_MERGE;
            end

            // one element per cycle, refetch the consumed side
            M_MERGE: begin
                o_we = 1'b1;
                o_re = 1'b1;
                n_k  = k_inc;
                if (take_l) begin
                    o_raddr  = l_inc[AW-1:0];
                    n_l      = l_inc;
                    n_rval   = rv;
                    n_q_is_l = 1'b1;
                    n_q_is_r = 1'b0;
                end else begin
                    o_raddr  = r_inc[AW-1:0];
                    n_r      = r_inc;
                    n_lval   = lv;
                    n_q_is_l = 1'b0;
                    n_q_is_r = 1'b1;
                end
                if (k_inc == r_hi) begin
                    if (hi_sum < n_ext) begin
                        n_lo    = hi_sum;
                        n_state = M_PRIME_L;
                    end else begin
                        // pass finished, swap source and destination
                        n_src_b = !r_src_b;
                        if (width_dbl < n_ext) begin
                            n_width = width_dbl;
                            n_lo    = '0;
                            n_state = M_PRIME_L;
                        end else begin
                            n_done  = 1'b1;
                            n_state = M_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // write index stays inside the current run
    a_k_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_MERGE) |-> (r_k < r_hi))
        else $error("merge write index past end of run");

    // read pointers never pass their run boundaries
    a_ptr_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_MERGE) |-> ((r_l <= r_mid) && (r_r <= r_hi)))
        else $error("merge read pointer out of run");

    // every element written came from exactly one side
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_MERGE) |-> ((r_k + r_mid) == (r_l + r_r)))
        else $error("merge element count mismatch");

endmodule

`default_nettype wire

[rtl/merge_sort_stable_unit.sv]
// merge_sort_stable_unit: stable ascending sorter for sets of signed 32-bit items
// loads a set into a ram, sorts it by merge passes, streams it out in order
// depends on msort_pkg, msort_ram, msort_merger
//
// usage:
//   input channel  i_valid / o_ready carries i_value and i_last_item. items are
//   taken one per cycle while the block is loading. up to MAX_ELEMENTS items are
//   stored; further items of the set are dropped and flag o_overflow.
//   the item with i_last_item set closes the set and starts the sort.
//   output channel o_valid / i_ready carries o_sorted_value, o_last_out (last
//   item of the set) and o_overflow. one result per stored item.
// pacing for a set of stored items:
//   load takes one item per cycle; sort time is set by the single read port
//   of the source ram (each merge run first fetches its two heads, then
//   moves one item a cycle);
//   emit moves one item per cycle while the receiver is ready.
// o_ready is low from the closing item until the last result enters the output
// register; a stalled receiver holds the emit sequence. reset empties the block.
`timescale 1ns / 1ps
`default_nettype none

module merge_sort_stable_unit #(
    parameter int MAX_ELEMENTS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [msort_pkg::DATA_W-1:0] i_value,
    input  wire logic                            i_last_item,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [msort_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                                 o_last_out,
    output logic                                 o_overflow
);

    import msort_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_top_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_e, n_e;
    logic          r_src_b, n_src_b;
    logic          r_start, n_start;
    logic          r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          in_acc;
    logic          has_room;
    logic          slot_free;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] e_inc;
    logic          ld_we;

    // emit read port
    logic          e_re;
    logic [AW-1:0] e_raddr;

    // merge engine ports
    logic              m_re;
    logic [AW-1:0]     m_raddr;
    logic              m_we;
    logic [AW-1:0]     m_waddr;
    logic [DATA_W-1:0] m_wdata;
    logic [DATA_W-1:0] m_q;
    t_sort_stat        stat;

    // ram ports
    logic              a_we, b_we, a_re, b_re;
    logic [AW-1:0]     a_waddr, a_raddr, b_raddr;
    logic [DATA_W-1:0] a_wdata, a_q, b_q, e_q;

    assign o_ready        = (r_state == S_LOAD);
    assign in_acc         = i_valid && o_ready;
    assign has_room       = (r_count < CW'(MAX_ELEMENTS));
    assign count_inc      = r_count + 1'b1;
    assign e_inc          = r_e + 1'b1;
    assign ld_we          = in_acc && has_room;
    assign slot_free      = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

    // element store: loaded from input, merge target on passes that read the buffer
    assign a_we    = ld_we || (m_we && stat.src_b);
    assign a_waddr = ld_we ? r_count[AW-1:0] : m_waddr;
    assign a_wdata = ld_we ? DATA_W'(i_value) : m_wdata;
    assign a_re    = (m_re && !stat.src_b) || (e_re && !n_src_b);
    assign a_raddr = m_re ? m_raddr : e_raddr;

    // merge buffer: merge target on passes that read the store
    assign b_we    = m_we && !stat.src_b;
    assign b_re    = (m_re && stat.src_b) || (e_re && n_src_b);
    assign b_raddr = m_re ? m_raddr : e_raddr;

    assign m_q = stat.src_b ? b_q : a_q;
    assign e_q = r_src_b ? b_q : a_q;

    msort_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (DATA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_q)
    );

    msort_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (DATA_W)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    msort_merger #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_merger (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_n     (r_n),
        .i_q     (m_q),
        .o_re    (m_re),
        .o_raddr (m_raddr),
        .o_we    (m_we),
        .o_waddr (m_waddr),
        .o_wdata (m_wdata),
        .o_stat  (stat)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_start     <= 1'b0;
            r_src_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_start     <= n_start;
            r_src_b     <= n_src_b;
            r_out_valid <= n_out_valid;
        end
    end

    // set size, emit index and output payload
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_e         <= n_e;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    // sequencer: load, sort, emit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_e         = r_e;
        n_src_b     = r_src_b;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        e_re        = 1'b0;
        e_raddr     = e_inc[AW-1:0];

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        n_count = count_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_n     = has_room ? count_inc : r_count;
                        n_start = 1'b1;
                        n_state = S_SORT;
                    end
                end
            end

            // wait for the merge passes, then fetch the first sorted item
            S_SORT: begin
                if (stat.done) begin
                    e_re    = 1'b1;
                    e_raddr = '0;
                    n_src_b = stat.src_b;
                    n_e     = '0;
                    n_state = S_EMIT;
                end
            end

            // move one item a cycle into the output register while the slot is free
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = e_q;
                    n_out_last  = (e_inc == r_n);
                    n_out_ovf   = r_ovf;
                    if (e_inc == r_n) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        e_re = 1'b1;
                        n_e  = e_inc;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // merge completion only arrives while the top level waits for it
    a_done_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> (r_state == S_SORT))
        else $error("sort done outside sort phase");

    // a sorted set always holds at least one item and fits the store
    a_set_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> ((r_n != '0) && (r_n <= CW'(MAX_ELEMENTS))))
        else $error("bad set size at sort");

    // emit index stays below the set size
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_e < r_n))
        else $error("emit index past set size");

    // the last item of a set leaves the block ready for the next set
    a_last_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && slot_free && (e_inc == r_n)) |=>
            (o_ready && o_last_out && o_valid))
        else $error("set end did not return to load");

endmodule

`default_nettype wire
